[hdl/flash_log_free_boundary_scan_macros.svh]
// Assertion helpers shared by the free-boundary scanner RTL.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef FLASH_LOG_FREE_BOUNDARY_SCAN_MACROS_SVH
`define FLASH_LOG_FREE_BOUNDARY_SCAN_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define FLOG_ASSERT_NOW(label, trig, chk, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (chk)) \
      else $error(msg);

// Check a consequence in the cycle after its trigger.
`define FLOG_ASSERT_NEXT(label, trig, chk, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (chk)) \
      else $error(msg);

`endif

[hdl/flog_pkg.sv]
package flog_pkg;

   localparam int ADDR_W = 32;
   localparam int OFF_W  = 21;
   localparam int DATA_W = 16;

   localparam logic [OFF_W-1:0]  MIN_UNIT_BYTES = 21'd4;
   localparam logic [OFF_W-1:0]  MAX_UNIT_BYTES = 21'd1048576;
   localparam logic [OFF_W-1:0]  SCAN_WINDOW    = 21'd2;
   localparam logic [DATA_W-1:0] ERASED_WORD    = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_START     = 2'd0,
      OP_READ_DATA = 2'd1,
      OP_READ_FAIL = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_READ_REQ = 2'd0,
      KIND_DONE     = 2'd1,
      KIND_FAIL     = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [ADDR_W-1:0] base_address;
      logic [OFF_W-1:0]  unit_size;
      logic [DATA_W-1:0] read_data;
   } req_item_type;

   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] read_address;
      logic [OFF_W-1:0]  free_offset;
   } rsp_item_type;

endpackage

[hdl/flog_scan_core.sv]
`include "flash_log_free_boundary_scan_macros.svh"

module flog_scan_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  flog_pkg::req_item_type item,
   output logic                  res_valid,
   output flog_pkg::rsp_item_type res
);
   import flog_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HEAD   = 2'd1,
      PH_TAIL   = 2'd2,
      PH_SEARCH = 2'd3
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [ADDR_W-1:0]  sector_base_ff, sector_base_in;
   logic [OFF_W-1:0]   sector_size_ff, sector_size_in;
   logic [OFF_W-1:0]   written_bound_ff, written_bound_in;
   logic [OFF_W-1:0]   erased_bound_ff, erased_bound_in;
   logic [OFF_W-1:0]   probe_offset_ff, probe_offset_in;

   logic               erased;
   logic               size_bad;
   logic [OFF_W:0]     probe_end;
   logic [OFF_W-1:0]   upd_w, upd_e, sn_w, sn_e;
   logic               sn_go;
   logic [OFF_W:0]     sn_sum;
   logic [OFF_W-1:0]   sn_mid, sn_probe;
   logic [ADDR_W-1:0]  probe_addr, tail_addr;

   assign erased    = (item.read_data == ERASED_WORD);
   assign size_bad  = (item.unit_size < MIN_UNIT_BYTES) || (item.unit_size > MAX_UNIT_BYTES);
   assign probe_end = {1'b0, probe_offset_ff} + {1'b0, SCAN_WINDOW};

   // Narrow the window after a search probe answers.
   always_comb begin
      if (erased) begin
         upd_w = written_bound_ff;
         upd_e = probe_offset_ff;
      end else begin
         upd_e = erased_bound_ff;
         if (probe_end > {1'b0, written_bound_ff}) begin
            upd_w = probe_end[OFF_W-1:0];
         end else begin
            upd_w = written_bound_ff + 21'd1;
         end
      end
   end

   // A written head restarts the search over the whole sector.
   assign sn_w = (phase_ff == PH_HEAD) ? '0 : upd_w;
   assign sn_e = (phase_ff == PH_HEAD) ? sector_size_ff : upd_e;

   assign sn_go  = (sn_e > sn_w) && ((sn_e - sn_w) > SCAN_WINDOW);
   assign sn_sum = {1'b0, sn_w} + {1'b0, sn_e};
   assign sn_mid = sn_sum[OFF_W:1];

   // Clamp the probe so the two-byte window stays inside the sector.
   always_comb begin
      if (({1'b0, sn_mid} + {1'b0, SCAN_WINDOW}) > {1'b0, sector_size_ff}) begin
         sn_probe = sector_size_ff - SCAN_WINDOW;
      end else begin
         sn_probe = sn_mid;
      end
   end

   assign probe_addr = sector_base_ff + {{(ADDR_W-OFF_W){1'b0}}, sn_probe};
   assign tail_addr  = sector_base_ff + {{(ADDR_W-OFF_W){1'b0}}, sector_size_ff}
                       - {{(ADDR_W-OFF_W){1'b0}}, SCAN_WINDOW};

   always_comb begin
      phase_in         = phase_ff;
      sector_base_in   = sector_base_ff;
      sector_size_in   = sector_size_ff;
      written_bound_in = written_bound_ff;
      erased_bound_in  = erased_bound_ff;
      probe_offset_in  = probe_offset_ff;
      res_valid        = 1'b0;
      res              = '0;
      res.kind         = KIND_READ_REQ;

      unique case (item.opcode)
         OP_START: begin
            res_valid = 1'b1;
            if (size_bad) begin
               phase_in = PH_IDLE;
               res.kind = KIND_FAIL;
            end else begin
               sector_base_in   = item.base_address;
               sector_size_in   = item.unit_size;
               written_bound_in = '0;
               erased_bound_in  = '0;
               probe_offset_in  = '0;
               phase_in         = PH_HEAD;
               res.read_address = item.base_address;
            end
         end
         OP_READ_FAIL: begin
            if (phase_ff != PH_IDLE) begin
               phase_in  = PH_IDLE;
               res_valid = 1'b1;
               res.kind  = KIND_FAIL;
            end
         end
         OP_READ_DATA: begin
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_TAIL: begin
                  phase_in        = PH_IDLE;
                  res_valid       = 1'b1;
                  res.kind        = KIND_DONE;
                  res.free_offset = erased ? '0 : sector_size_ff;
               end
               PH_HEAD, PH_SEARCH: begin
                  res_valid = 1'b1;
                  if ((phase_ff == PH_HEAD) && erased) begin
                     phase_in         = PH_TAIL;
                     res.read_address = tail_addr;
                  end else begin
                     written_bound_in = sn_w;
                     erased_bound_in  = sn_e;
                     if (sn_go) begin
                        probe_offset_in  = sn_probe;
                        phase_in         = PH_SEARCH;
                        res.read_address = probe_addr;
                     end else begin
                        phase_in        = PH_IDLE;
                        res.kind        = KIND_DONE;
                        res.free_offset = sn_w;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         sector_base_ff   <= '0;
         sector_size_ff   <= '0;
         written_bound_ff <= '0;
         erased_bound_ff  <= '0;
         probe_offset_ff  <= '0;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         sector_base_ff   <= sector_base_in;
         sector_size_ff   <= sector_size_in;
         written_bound_ff <= written_bound_in;
         erased_bound_ff  <= erased_bound_in;
         probe_offset_ff  <= probe_offset_in;
      end
   end

   // An outstanding search probe lies inside the open window.
   `FLOG_ASSERT_NOW(a_probe_in_window, phase_ff == PH_SEARCH,
      (probe_offset_ff >= written_bound_ff) && (probe_offset_ff < erased_bound_ff),
      "search probe outside window")

   // The probe window never reaches past the sector end.
   `FLOG_ASSERT_NOW(a_probe_in_sector, phase_ff == PH_SEARCH,
      probe_end <= {1'b0, sector_size_ff}, "search probe past sector end")

   // A finished scan leaves the scanner idle.
   `FLOG_ASSERT_NEXT(a_done_goes_idle, step_en && res_valid && (res.kind == KIND_DONE),
      phase_ff == PH_IDLE, "scanner busy after done")

   // Read data while idle produces nothing.
   `FLOG_ASSERT_NOW(a_idle_data_silent,
      (phase_ff == PH_IDLE) && (item.opcode == OP_READ_DATA), !res_valid,
      "result from stray read data")

endmodule

[hdl/flash_log_free_boundary_scan.sv]
// Flash log free-boundary scanner.
// Finds the first unwritten byte offset of an append-only flash sector by
// driving two-byte probe reads and consuming their answers.
// Request channel (req_): tuser carries the opcode (start scan, read data
// returned, read failed); tdata carries the sector base, size and read word.
// Response channel (rsp_): tuser carries the kind (read request, scan done,
// scan failed); tdata carries the probe address and the free offset.
// Each request transfer yields at most one response transfer; stray read
// answers while idle and the unused opcode yield none.
// A request transfer loads the request register; the scan step then loads the
// response register from it, and the response transfer leaves from there.
// Throughput is one request per cycle while responses drain; the scan step is
// a single compare, add and halving on 21-bit bounds between the two registers.
// Reset (synchronous, active high) empties both registers and returns the
// scanner to idle with all bounds cleared.
// When the receiver stalls, the pending response holds; the queued request
// waits in its register and req_tready drops until the response moves.
module flash_log_free_boundary_scan (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // base_address[31:0], unit_size[52:32], read_data[68:53]
   input  logic [1:0]  req_tuser,  // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // read_address[31:0], free_offset[52:32]
   output logic [1:0]  rsp_tuser   // kind[1:0]
);
   import flog_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic         req_fire;
   logic         advance;
   logic         core_res_valid;
   rsp_item_type core_res;

   // Step the scanner whenever a request is held and the response slot is free
   // or draining this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // Unpack the request transfer.
   always_comb begin
      in_item_in              = in_item_ff;
      if (req_fire) begin
         in_item_in.opcode       = req_tuser;
         in_item_in.base_address = req_tdata[31:0];
         in_item_in.unit_size    = req_tdata[52:32];
         in_item_in.read_data    = req_tdata[68:53];
      end
   end

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   flog_scan_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .item      (in_item_ff),
      .res_valid (core_res_valid),
      .res       (core_res)
   );

   // Load a fresh result on a step, drop the old one once transferred.
   always_comb begin
      out_item_in = out_item_ff;
      if (advance) begin
         out_valid_in = core_res_valid;
         out_item_in  = core_res;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.kind;
   assign rsp_tdata  = {3'b000, out_item_ff.free_offset, out_item_ff.read_address};

endmodule
